// ===== src/tehb_pkg.sv =====
package tehb_pkg;

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
	localparam int unsigned ID_BITS = 28;
	localparam int unsigned BUCKET_BITS = 18;
	localparam int unsigned TAG_LSB = ID_BITS + BUCKET_BITS;
	localparam logic [17:0] STR_TAG = 18'd2;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
	localparam logic [1:0] REG_BUCKET_COUNT = 2'd1;
	localparam logic [1:0] REG_RELATION_TAG = 2'd2;
	localparam logic [1:0] REG_START_ID = 2'd3;

	// encoded column handed from front to back
	typedef struct packed {
		logic [63:0] word;
		logic        tuple_end;
	} col_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_MOD,
		ST_EMIT_COL,
		ST_EMIT_TID
	} back_state_t;

endpackage

// ===== src/tehb_front.sv =====
module tehb_front #(
	parameter int MAX_COLUMNS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 is_string,
	input  logic [31:0]          int_value,
	input  logic [27:0]          string_index,
	input  logic [5:0]           column_count,
	output logic                 q_valid,
	input  logic                 q_ready,
	output tehb_pkg::col_t       q_data
);
	import tehb_pkg::*;

	logic [5:0] column_index_q;
	logic [5:0] eff_cols;
	logic [6:0] received;
	logic [63:0] enc;
	col_t slot_q [2];
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	logic push, pop;

	// effective arity, clamped
	always_comb begin
		eff_cols = column_count;
		if (column_count == 6'd0) eff_cols = 6'd1;
		if (column_count > 6'(MAX_COLUMNS)) eff_cols = 6'(MAX_COLUMNS);
	end

	assign received = {1'b0, column_index_q} + 7'd1;

	// column encoding
	always_comb begin
		if (is_string) enc = {STR_TAG, 18'd0, string_index};
		else enc = {36'd0, int_value[27:0]};
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = slot_q[rd_ptr_q];

	// column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_index_q <= '0;
		end else if (push) begin
			if (received < {1'b0, eff_cols}) column_index_q <= received[5:0];
			else column_index_q <= '0;
		end
	end

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].word <= enc;
			slot_q[wr_ptr_q].tuple_end <= !(received < {1'b0, eff_cols});
		end
	end

endmodule

// ===== src/tehb_back.sv =====
module tehb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  tehb_pkg::col_t       q_data,
	input  logic [17:0]          bucket_count,
	input  logic [17:0]          relation_tag,
	input  logic [27:0]          start_id,
	input  logic                 start_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          out_word,
	output logic                 out_is_tid,
	output logic                 out_last
);
	import tehb_pkg::*;

	back_state_t state_q, state_d;
	logic [63:0] hash_q, word_q, fold;
	logic [17:0] rem_q;
	logic        end_q;
	logic [2:0]  byte_q;
	logic [5:0]  bit_q;
	logic [27:0] counter_q;
	logic [18:0] trial;
	logic [63:0] cur;

	// one xor-multiply step per byte; the prime is 2^40 + 0x1b3, so shift-add
	assign cur = hash_q ^ {56'd0, word_q[8*byte_q +: 8]};
	assign fold = (cur << 40) + (cur << 8) + (cur << 7) + (cur << 5) + (cur << 4)
		+ (cur << 1) + cur;

	// restoring remainder, one bit a cycle
	assign trial = {rem_q, hash_q[bit_q]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_FOLD;
			ST_FOLD: if (byte_q == 3'd7) state_d = end_q ? ST_MOD : ST_EMIT_COL;
			ST_MOD: if (bit_q == 6'd0) state_d = ST_EMIT_COL;
			ST_EMIT_COL: if (out_ready) state_d = end_q ? ST_EMIT_TID : ST_IDLE;
			ST_EMIT_TID: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// output decode
	always_comb begin
		q_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT_COL) || (state_q == ST_EMIT_TID);
		out_is_tid = (state_q == ST_EMIT_TID);
		out_last = out_is_tid;
		out_word = out_is_tid
			? {relation_tag, (bucket_count == 18'd0) ? 18'd0 : rem_q, counter_q}
			: word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q <= FNV_BASIS;
			counter_q <= '0;
			byte_q <= '0;
			bit_q <= '0;
			end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_load) counter_q <= start_id;
			else if (state_q == ST_EMIT_TID && out_ready) counter_q <= counter_q + 28'd1;
			unique case (state_q)
				ST_IDLE: begin
					byte_q <= '0;
					end_q <= q_data.tuple_end;
				end
				ST_FOLD: begin
					hash_q <= fold;
					byte_q <= byte_q + 3'd1;
					bit_q <= 6'd63;
				end
				ST_MOD: bit_q <= bit_q - 6'd1;
				ST_EMIT_COL: ;
				ST_EMIT_TID: if (out_ready) hash_q <= FNV_BASIS;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) word_q <= q_data.word;
		if (state_q == ST_FOLD) rem_q <= '0;
		if (state_q == ST_MOD) begin
			if (trial >= {1'b0, bucket_count}) rem_q <= 18'(trial - {1'b0, bucket_count});
			else rem_q <= 18'(trial);
		end
	end

endmodule

// ===== src/tuple_encode_hash_bucket_id_unit.sv =====
// tuple encoder with fnv-1a 64 hash partitioning
// s_axis: one column item; tdata = int_value[31:0], string_index[59:32],
//   zero filled to 64 bits; tuser = is_string
// m_axis: tdata = 64-bit word, tuser = is_tuple_id, tlast = last of tuple
// each column yields its encoded word; the column that completes a tuple
// also yields the tuple id (relation tag, hash mod bucket count, counter)
// cfg: cfg_index selects column_count, bucket_count, relation_tag,
//   start_tuple_id; always ready, write only while idle
// a front stage encodes and counts columns into a two-entry queue; the
// back stage folds a word with one shift-add fnv multiply a byte,
// then one bit of the bucket remainder a cycle at tuple end
// the back takes no new column until the last has left, nor while
// an output stall lasts; results leave through a held output register
// reset: hash at offset basis, column count 2, bucket count 1, tag 256,
// counter 0; a stalled receiver holds the back, the queue fills, then
// s_axis_tready drops
module tuple_encode_hash_bucket_id_unit #(
	parameter int MAX_COLUMNS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // int_value, string_index, zero pad
	input  logic        s_axis_tuser,  // is_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // word
	output logic        m_axis_tuser,  // is_tuple_id
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [27:0] cfg_data
);
	import tehb_pkg::*;

	logic [5:0]  column_count_q;
	logic [17:0] bucket_count_q, relation_tag_q;
	logic        cfg_we, start_load;
	logic        q_valid, q_ready;
	col_t        q_data;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign start_load = cfg_we && (cfg_index == REG_START_ID);

	// configuration registers; the start id loads the counter directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 6'd2;
			bucket_count_q <= 18'd1;
			relation_tag_q <= 18'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMN_COUNT: column_count_q <= cfg_data[5:0];
				REG_BUCKET_COUNT: bucket_count_q <= cfg_data[17:0];
				REG_RELATION_TAG: relation_tag_q <= cfg_data[17:0];
				REG_START_ID: ;
				default: ;
			endcase
		end
	end

	tehb_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.is_string(s_axis_tuser), .int_value(s_axis_tdata[31:0]),
		.string_index(s_axis_tdata[59:32]), .column_count(column_count_q),
		.q_valid, .q_ready, .q_data
	);

	tehb_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.bucket_count(bucket_count_q), .relation_tag(relation_tag_q),
		.start_id(cfg_data), .start_load,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(m_axis_tdata), .out_is_tid(m_axis_tuser), .out_last(m_axis_tlast)
	);

	// tuple id always ends a tuple
	a_tid_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
		else $error("tuple id and last disagree");

	// a tuple id follows straight after its ending column
	a_tid_after_col: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tuser && u_back.end_q)
		|=> (m_axis_tvalid && m_axis_tuser))
		else $error("missing tuple id");

	// string words carry the string tag
	a_str_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser && m_axis_tdata[63:46] != 18'd0)
		|-> (m_axis_tdata[63:46] == STR_TAG))
		else $error("bad column tag");

endmodule
